// File: rtl/core/affine_warp_nearest_core_defines.svh
// ----------------------------------------------------------------------------
// Affine warp core assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef AFFINE_WARP_NEAREST_CORE_DEFINES_SVH
`define AFFINE_WARP_NEAREST_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AWN_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication on a later cycle, the delay given as a constant cycle count.
`define AWN_ASSERT_DELAY(label, clk, rst_n, ante, dly, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> ##dly (cons)) else $error(msg);

`endif

// File: rtl/core/awn_pkg.sv
// ----------------------------------------------------------------------------
// Affine warp core package
// Types, register indexes and size constants shared by the warp core files.
// ----------------------------------------------------------------------------
package awn_pkg;

    localparam int MAX_SRC_WIDTH_DEF  = 256;
    localparam int MAX_SRC_HEIGHT_DEF = 256;
    localparam int FRAC_BITS_DEF      = 16;

    localparam int COORD_W     = 12;
    localparam int PIXEL_W     = 8;
    localparam int COEF_W      = 32;
    localparam int SIZE_W      = 9;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 32;
    // Limits up to 4096 need 13 bits.
    localparam int LIM_W       = COORD_W + 1;
    // Coefficient times a zero-extended coordinate, and the three-term sum.
    localparam int PROD_W      = COEF_W + COORD_W + 1;
    localparam int SUM_W       = PROD_W + 1;

    typedef enum logic
    {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } awn_cmd_t;

    localparam logic [CFG_INDEX_W-1:0] REG_COEF_XU    = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_XV    = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_YU    = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_YV    = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_OFF_X      = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_OFF_Y      = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_SRC_WIDTH  = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SRC_HEIGHT = 4'd7;

    typedef struct packed
    {
        awn_cmd_t             cmd;
        logic [COORD_W-1:0]   column;
        logic [COORD_W-1:0]   row;
        logic [PIXEL_W-1:0]   pixel_in;
    } awn_in_t;

    typedef struct packed
    {
        logic [PIXEL_W-1:0]   pixel_out;
        logic                 outside;
    } awn_out_t;

    typedef struct packed
    {
        logic signed [COEF_W-1:0] coef_xu;
        logic signed [COEF_W-1:0] coef_xv;
        logic signed [COEF_W-1:0] coef_yu;
        logic signed [COEF_W-1:0] coef_yv;
        logic signed [COEF_W-1:0] off_x;
        logic signed [COEF_W-1:0] off_y;
        logic [SIZE_W-1:0]        src_width;
        logic [SIZE_W-1:0]        src_height;
    } awn_cfg_t;

    // One memory access handed from the mapping pipeline to the image memory.
    typedef struct packed
    {
        logic                 valid;
        awn_cmd_t             cmd;
        logic                 hit;
        logic [COORD_W-1:0]   x;
        logic [COORD_W-1:0]   y;
        logic [PIXEL_W-1:0]   pixel;
    } awn_access_t;

endpackage

// File: rtl/core/awn_map.sv
// ----------------------------------------------------------------------------
// Affine warp coordinate mapper
// Four-stage pipeline: capture, multiply, sum, truncate with bound test,
// giving one memory access per accepted command.
// ----------------------------------------------------------------------------
module awn_map #(
    parameter int MAX_SRC_WIDTH  = awn_pkg::MAX_SRC_WIDTH_DEF,
    parameter int MAX_SRC_HEIGHT = awn_pkg::MAX_SRC_HEIGHT_DEF,
    parameter int FRAC_BITS      = awn_pkg::FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  awn_pkg::awn_in_t     in_item,
    input  awn_pkg::awn_cfg_t    cfg,
    output awn_pkg::awn_access_t access
);

    localparam int SUM_W = awn_pkg::SUM_W;
    localparam int PROD_W = awn_pkg::PROD_W;
    localparam int LIM_W = awn_pkg::LIM_W;
    localparam int IP_W = SUM_W - FRAC_BITS;
    localparam logic [LIM_W-1:0] MAX_W_L = LIM_W'(MAX_SRC_WIDTH);
    localparam logic [LIM_W-1:0] MAX_H_L = LIM_W'(MAX_SRC_HEIGHT);

    logic                         v1_reg, v2_reg, v3_reg;
    awn_pkg::awn_in_t             item1_reg, item2_reg, item3_reg;
    logic signed [PROD_W-1:0]     p_xu_reg, p_xv_reg, p_yu_reg, p_yv_reg;
    logic signed [SUM_W-1:0]      fx_reg, fy_reg;
    awn_pkg::awn_access_t         access_reg;

    logic signed [awn_pkg::COORD_W:0] u_s, v_s;
    logic signed [SUM_W-1:0]      fx_next, fy_next;
    logic [LIM_W-1:0]             lim_x, lim_y;
    logic                         in_x, in_y, load_hit;
    logic [awn_pkg::COORD_W-1:0]  x_q, y_q;
    awn_pkg::awn_access_t         access_next;

    // Stage 1: capture the command. Stage 4 registers the memory access.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            access_reg.valid <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            access_reg <= access_next;
        end
    end

    assign u_s = $signed({1'b0, item1_reg.column});
    assign v_s = $signed({1'b0, item1_reg.row});

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            item1_reg <= in_item;
        end
        // Stage 2: the four products.
        item2_reg <= item1_reg;
        p_xu_reg  <= cfg.coef_xu * u_s;
        p_xv_reg  <= cfg.coef_xv * v_s;
        p_yu_reg  <= cfg.coef_yu * u_s;
        p_yv_reg  <= cfg.coef_yv * v_s;
        // Stage 3: sums with offsets.
        item3_reg <= item2_reg;
        fx_reg    <= fx_next;
        fy_reg    <= fy_next;
    end

    assign fx_next = p_xu_reg + p_xv_reg + cfg.off_x;
    assign fy_next = p_yu_reg + p_yv_reg + cfg.off_y;

    // Effective image size is the smaller of the register and the memory.
    assign lim_x = (MAX_W_L < LIM_W'(cfg.src_width)) ? MAX_W_L : LIM_W'(cfg.src_width);
    assign lim_y = (MAX_H_L < LIM_W'(cfg.src_height)) ? MAX_H_L : LIM_W'(cfg.src_height);

    // A negative value strictly above minus one truncates to zero and is inside.
    always_comb
    begin
        if (fx_reg[SUM_W-1])
        begin
            in_x = (&fx_reg[SUM_W-1:FRAC_BITS]) && (|fx_reg[FRAC_BITS-1:0]) && (lim_x != '0);
            x_q  = '0;
        end
        else
        begin
            in_x = fx_reg[SUM_W-1:FRAC_BITS] < IP_W'(lim_x);
            x_q  = fx_reg[FRAC_BITS +: awn_pkg::COORD_W];
        end
        if (fy_reg[SUM_W-1])
        begin
            in_y = (&fy_reg[SUM_W-1:FRAC_BITS]) && (|fy_reg[FRAC_BITS-1:0]) && (lim_y != '0);
            y_q  = '0;
        end
        else
        begin
            in_y = fy_reg[SUM_W-1:FRAC_BITS] < IP_W'(lim_y);
            y_q  = fy_reg[FRAC_BITS +: awn_pkg::COORD_W];
        end
    end

    assign load_hit = ({1'b0, item3_reg.column} < MAX_W_L) && ({1'b0, item3_reg.row} < MAX_H_L);

    always_comb
    begin
        access_next.valid = v3_reg;
        access_next.cmd   = item3_reg.cmd;
        access_next.pixel = item3_reg.pixel_in;
        if (item3_reg.cmd == awn_pkg::CMD_QUERY)
        begin
            access_next.hit = in_x && in_y;
            access_next.x   = x_q;
            access_next.y   = y_q;
        end
        else
        begin
            access_next.hit = load_hit;
            access_next.x   = item3_reg.column;
            access_next.y   = item3_reg.row;
        end
    end

    assign access = access_reg;

endmodule

// File: rtl/core/awn_mem.sv
// ----------------------------------------------------------------------------
// Affine warp source image memory
// Single-port synchronous image store with a registered read and the
// result strobe that goes with it.
// ----------------------------------------------------------------------------
module awn_mem #(
    parameter int MAX_SRC_WIDTH  = awn_pkg::MAX_SRC_WIDTH_DEF,
    parameter int MAX_SRC_HEIGHT = awn_pkg::MAX_SRC_HEIGHT_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  awn_pkg::awn_access_t access,
    output logic                 result_valid,
    output awn_pkg::awn_out_t    result
);

    localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int XW = $clog2(MAX_SRC_WIDTH);
    localparam int YW = $clog2(MAX_SRC_HEIGHT);

    logic [awn_pkg::PIXEL_W-1:0] mem [DEPTH];
    logic [awn_pkg::PIXEL_W-1:0] rd_data_reg;
    logic                        result_valid_reg;
    logic                        outside_reg;
    logic [ADDR_W-1:0]           addr;
    logic                        wr_en;

    // Row-major with a pitch of the maximum width.
    assign addr = ADDR_W'(access.y[YW-1:0]) * ADDR_W'(MAX_SRC_WIDTH)
                + ADDR_W'(access.x[XW-1:0]);
    assign wr_en = access.valid && (access.cmd == awn_pkg::CMD_LOAD) && access.hit;

    // Accesses reach the memory in command order, so a query always sees
    // every load issued before it.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= access.pixel;
        end
        rd_data_reg <= mem[addr];
        outside_reg <= !access.hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= access.valid && (access.cmd == awn_pkg::CMD_QUERY);
        end
    end

    assign result_valid     = result_valid_reg;
    assign result.outside   = outside_reg;
    assign result.pixel_out = outside_reg ? '0 : rd_data_reg;

endmodule

// File: rtl/core/affine_warp_nearest_core.sv
// ----------------------------------------------------------------------------
// Affine warp nearest-neighbor core
// Inverse affine warp of an 8-bit image held in on-chip memory.
// ----------------------------------------------------------------------------
// Usage:
//   A command is taken at a clock edge where start is high and busy is low.
//   busy stays low, so a command may be issued in every cycle. A load
//   command writes pixel_in at (column, row) and gives no result; a query
//   maps (column, row) through the affine registers and returns one result.
//   A query passes the capture, multiply, sum, access and memory read
//   registers; result_valid is then high for exactly one cycle, and results
//   come in command order. Throughput is one command per cycle, set by the
//   single memory port that serves one load or one query read each cycle.
//   The receiver cannot stall; it must take each result in its strobe cycle.
//   Registers are written on the cfg channel (cfg_ready is always high); the
//   user must write them only while no command is in flight, which the block
//   does not enforce; indexes past the register list are ignored.
//   Reset clears the pipeline and restores the register defaults. The image
//   memory is not cleared: pixels must be loaded before they are queried.
// ----------------------------------------------------------------------------
module affine_warp_nearest_core #(
    parameter int MAX_SRC_WIDTH  = awn_pkg::MAX_SRC_WIDTH_DEF,
    parameter int MAX_SRC_HEIGHT = awn_pkg::MAX_SRC_HEIGHT_DEF,
    parameter int FRAC_BITS      = awn_pkg::FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  awn_pkg::awn_in_t                in_item,
    output logic                            result_valid,
    output awn_pkg::awn_out_t               result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [awn_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [awn_pkg::CFG_DATA_W-1:0]  cfg_data
);

    awn_pkg::awn_cfg_t    cfg_reg;
    awn_pkg::awn_access_t access;
    logic                 in_valid;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign in_valid  = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.coef_xu    <= 32'sd65536;
            cfg_reg.coef_xv    <= '0;
            cfg_reg.coef_yu    <= '0;
            cfg_reg.coef_yv    <= 32'sd65536;
            cfg_reg.off_x      <= '0;
            cfg_reg.off_y      <= '0;
            cfg_reg.src_width  <= 9'd256;
            cfg_reg.src_height <= 9'd256;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                awn_pkg::REG_COEF_XU:    cfg_reg.coef_xu    <= cfg_data;
                awn_pkg::REG_COEF_XV:    cfg_reg.coef_xv    <= cfg_data;
                awn_pkg::REG_COEF_YU:    cfg_reg.coef_yu    <= cfg_data;
                awn_pkg::REG_COEF_YV:    cfg_reg.coef_yv    <= cfg_data;
                awn_pkg::REG_OFF_X:      cfg_reg.off_x      <= cfg_data;
                awn_pkg::REG_OFF_Y:      cfg_reg.off_y      <= cfg_data;
                awn_pkg::REG_SRC_WIDTH:  cfg_reg.src_width  <= cfg_data[awn_pkg::SIZE_W-1:0];
                awn_pkg::REG_SRC_HEIGHT: cfg_reg.src_height <= cfg_data[awn_pkg::SIZE_W-1:0];
                default:                 cfg_reg <= cfg_reg;
            endcase
        end
    end

    awn_map #(
        .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
        .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
        .FRAC_BITS      (FRAC_BITS)
    ) u_map (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_item  (in_item),
        .cfg      (cfg_reg),
        .access   (access)
    );

    awn_mem #(
        .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
        .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT)
    ) u_mem (
        .clk          (clk),
        .rst_n        (rst_n),
        .access       (access),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// File: rtl/core/awn_check.sv
// ----------------------------------------------------------------------------
// Affine warp core port checker
// Watches the top-level ports for result timing and outside results.
// ----------------------------------------------------------------------------
`include "affine_warp_nearest_core_defines.svh"

module awn_check (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input awn_pkg::awn_in_t  in_item,
    input logic              result_valid,
    input awn_pkg::awn_out_t result
);

    logic query_xfer;

    assign query_xfer = start && !busy && (in_item.cmd == awn_pkg::CMD_QUERY);

    // Every query transfer yields a result strobe.
    `AWN_ASSERT_DELAY(a_query_gives_result, clk, rst_n, query_xfer, 5, result_valid, "query without result")

    // Loads give no result, so a strobe must trace back to a query.
    `AWN_ASSERT_IMPLY(a_result_from_query, clk, rst_n, result_valid, $past(query_xfer, 5), "result without query")

    // An outside result carries a zero pixel.
    `AWN_ASSERT_IMPLY(a_outside_zero, clk, rst_n, result_valid && result.outside, result.pixel_out == '0, "outside result with nonzero pixel")

endmodule

bind affine_warp_nearest_core awn_check u_awn_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_item      (in_item),
    .result_valid (result_valid),
    .result       (result)
);
